// ===== hw/rtl/glm3_pkg.sv =====
// ----------------------------------------------------------------------------
// glm3_pkg: shared types and constants for the 3x3 local maximum detector
// Holds the register map, the word layouts on both stream sides, the
// neighbor offset tables and the structs that pass between the modules.
// ----------------------------------------------------------------------------
package glm3_pkg;

	// Defaults for the top level parameters.
	localparam int DEF_MAX_ROWS     = 1024;
	localparam int DEF_MAX_COLS     = 1024;
	localparam int DEF_HEIGHT_WIDTH = 16;

	// Register file.
	localparam int CFG_W       = 11;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam int RESET_DIM   = 1024;

	typedef enum logic {
		REG_GRID_ROWS = 1'b0,
		REG_GRID_COLS = 1'b1
	} reg_idx_t;

	// Input word kinds carried on s_tuser.
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	// Output word layout.
	localparam int COORD_W     = 10;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_USED_W  = 2 * COORD_W + 1;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TUSER_W = 1;

	// Result buffer depth; it also bounds the words in flight.
	localparam int FIFO_DEPTH = 4;

	// Neighbor offsets, clockwise from the cell above.
	localparam int NB_COUNT = 8;
	localparam logic signed [1:0] NB_DROW [NB_COUNT] = '{-2'sd1, -2'sd1, 2'sd0, 2'sd1,
		2'sd1, 2'sd1, 2'sd0, -2'sd1};
	localparam logic signed [1:0] NB_DCOL [NB_COUNT] = '{2'sd0, 2'sd1, 2'sd1, 2'sd1,
		2'sd0, -2'sd1, -2'sd1, -2'sd1};

	// Position of the cell being decided, with its grid border flags.
	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               top;
		logic               bottom;
		logic               left;
		logic               right;
	} cell_info_t;

	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               peak;
	} result_t;

	// A zero is taken as one, and values above the limit saturate to it.
	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] value,
		input int limit);
		logic [CFG_W-1:0] v;
		v = value;
		if (v == '0) begin
			v = CFG_W'(1);
		end
		if (int'(v) > limit) begin
			v = CFG_W'(limit);
		end
		return v;
	endfunction

endpackage

// ===== hw/rtl/glm3_line_ram.sv =====
// ----------------------------------------------------------------------------
// glm3_line_ram: line store memory
// One write port and one read port; read data is registered, so a read
// returns its entry in the cycle after the address is presented.
// ----------------------------------------------------------------------------
module glm3_line_ram #(
	parameter int DEPTH  = glm3_pkg::DEF_MAX_COLS,
	parameter int DATA_W = 2 * glm3_pkg::DEF_HEIGHT_WIDTH,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/glm3_peak_eval.sv =====
// ----------------------------------------------------------------------------
// glm3_peak_eval: 3x3 window and peak decision
// Shifts one column of three heights into the window per word and, in the
// cycle after the shift, compares the center against its in-grid neighbors.
// ----------------------------------------------------------------------------
module glm3_peak_eval #(
	parameter int HEIGHT_WIDTH = glm3_pkg::DEF_HEIGHT_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           shift_en,
	input  logic signed [HEIGHT_WIDTH-1:0] col_top,
	input  logic signed [HEIGHT_WIDTH-1:0] col_mid,
	input  logic signed [HEIGHT_WIDTH-1:0] col_bot,
	input  glm3_pkg::cell_info_t           info_s1,
	output logic                           res_valid,
	output glm3_pkg::result_t              res
);

	// Indexed [column][row]; column 0 is the oldest, row 0 the oldest line.
	logic signed [HEIGHT_WIDTH-1:0] win_q [3][3];
	glm3_pkg::cell_info_t           info_s2;
	logic                           vld_s2;
	logic                           peak;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[c][r] <= '0;
				end
			end
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= shift_en;
			if (shift_en) begin
				win_q[0]    <= win_q[1];
				win_q[1]    <= win_q[2];
				win_q[2][0] <= col_top;
				win_q[2][1] <= col_mid;
				win_q[2][2] <= col_bot;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			info_s2 <= info_s1;
		end
	end

	always_comb begin
		int  dr;
		int  dc;
		logic skip;
		peak = 1'b1;
		for (int t = 0; t < glm3_pkg::NB_COUNT; t++) begin
			dr   = int'(glm3_pkg::NB_DROW[t]);
			dc   = int'(glm3_pkg::NB_DCOL[t]);
			skip = (dr < 0 && info_s2.top) || (dr > 0 && info_s2.bottom) ||
				(dc < 0 && info_s2.left) || (dc > 0 && info_s2.right);
			if (!skip && (win_q[1][1] < win_q[1 + dc][1 + dr])) begin
				peak = 1'b0;
			end
		end
	end

	assign res_valid = vld_s2;
	assign res.valid = info_s2.valid;
	assign res.row   = info_s2.row;
	assign res.col   = info_s2.col;
	assign res.peak  = info_s2.valid & peak;

endmodule

// ===== hw/rtl/glm3_out_fifo.sv =====
// ----------------------------------------------------------------------------
// glm3_out_fifo: result buffer
// Small first-in first-out store that decouples the decision pipeline
// from backpressure on the output stream.
// ----------------------------------------------------------------------------
module glm3_out_fifo #(
	parameter int DEPTH = glm3_pkg::FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  glm3_pkg::result_t push_data,
	input  logic              pop,
	output logic              out_valid,
	output glm3_pkg::result_t out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	glm3_pkg::result_t slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[rd_ptr_q];

endmodule

// ===== hw/rtl/grid_local_maximum_3x3_core.sv =====
// ----------------------------------------------------------------------------
// grid_local_maximum_3x3_core: 3x3 local maximum detector over a raster grid
// Takes one word per clock while the slave side is ready and returns one
// result word for each. A word is read from the line memory in the cycle
// it is accepted, the memory entry is rewritten and the window shifted in
// the next cycle, and the peak decision is made in the cycle after that.
// The line memory does one read and one write per cycle, which sets the
// rate at one word per clock; a four-entry result buffer absorbs output
// stalls, and the slave side stops only when four words are accepted but
// not yet delivered. Each result that decides a cell decides the one that
// arrived grid_cols+1 words earlier.
// ----------------------------------------------------------------------------
module grid_local_maximum_3x3_core #(
	parameter int MAX_ROWS     = glm3_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS     = glm3_pkg::DEF_MAX_COLS,
	parameter int HEIGHT_WIDTH = glm3_pkg::DEF_HEIGHT_WIDTH,
	parameter int IN_TDATA_W   = ((HEIGHT_WIDTH + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Slave stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [IN_TDATA_W-1:0]              s_tdata,   // [0+:H] height
	input  logic [glm3_pkg::IN_TUSER_W-1:0]    s_tuser,   // [0] req_type
	// Master stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [glm3_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [9:0] cell_row, [19:10] cell_col,
	                                                      // [20] is_peak, [23:21] zero
	output logic [glm3_pkg::OUT_TUSER_W-1:0]   m_tuser,   // [0] out_valid
	// Register port.
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [glm3_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [glm3_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [glm3_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);

	localparam int CFG_W   = glm3_pkg::CFG_W;
	localparam int CW      = glm3_pkg::COORD_W;
	localparam int COL_AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int WARM_W  = $clog2(MAX_COLS + 2);
	localparam int W_A     = (COL_AW > CFG_W) ? COL_AW : CFG_W;
	localparam int W_B     = (ROW_W > W_A) ? ROW_W : W_A;
	localparam int W_C     = (WARM_W > W_B) ? WARM_W : W_B;
	localparam int EXT_W   = W_C + 1;
	localparam int ENTRY_W = 2 * HEIGHT_WIDTH;
	localparam int DEPTH   = glm3_pkg::FIFO_DEPTH;
	localparam int FILL_W  = $clog2(DEPTH + 1);

	// Configuration.
	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;
	logic             cfg_wr;
	glm3_pkg::reg_idx_t cfg_sel;

	// Position counters.
	logic [COL_AW-1:0] in_col_q;
	logic [WARM_W-1:0] warm_cnt_q;
	logic [ROW_W-1:0]  orow_q;
	logic [COL_AW-1:0] ocol_q;

	logic              in_accept;
	logic              out_accept;
	logic [EXT_W-1:0]  rows_x;
	logic [EXT_W-1:0]  cols_x;
	logic              in_col_last;
	logic              cell_valid;
	logic              ocol_last;
	logic              orow_last;
	logic              cell_last;
	glm3_pkg::cell_info_t info_s0;

	// Read-modify-write stage.
	logic                           vld_s1;
	logic [COL_AW-1:0]              idx_s1;
	logic signed [HEIGHT_WIDTH-1:0] h_s1;
	glm3_pkg::cell_info_t           info_s1;
	logic                           fwd_s1;
	logic [ENTRY_W-1:0]             fwd_data_s1;
	logic [ENTRY_W-1:0]             rd_data;
	logic [ENTRY_W-1:0]             entry;
	logic [ENTRY_W-1:0]             wr_data;
	logic signed [HEIGHT_WIDTH-1:0] old_a;
	logic signed [HEIGHT_WIDTH-1:0] old_b;
	logic signed [HEIGHT_WIDTH-1:0] h_in;

	logic              res_valid;
	glm3_pkg::result_t res;
	glm3_pkg::result_t out_res;
	logic [FILL_W-1:0] inflight_q;

	// ---------------------------------------------------------------- registers
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_sel = glm3_pkg::reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;

	always_comb begin
		unique case (cfg_sel)
			glm3_pkg::REG_GRID_ROWS: prdata = glm3_pkg::APB_DATA_W'(rows_q);
			glm3_pkg::REG_GRID_COLS: prdata = glm3_pkg::APB_DATA_W'(cols_q);
			default:                 prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- positions
	assign in_accept  = s_tvalid & s_tready;
	assign out_accept = m_tvalid & m_tready;

	assign rows_x      = EXT_W'(rows_q);
	assign cols_x      = EXT_W'(cols_q);
	assign in_col_last = (EXT_W'(in_col_q) + EXT_W'(1) == cols_x);
	assign cell_valid  = (EXT_W'(warm_cnt_q) == cols_x + EXT_W'(1));
	assign ocol_last   = (EXT_W'(ocol_q) + EXT_W'(1) == cols_x);
	assign orow_last   = (EXT_W'(orow_q) + EXT_W'(1) == rows_x);
	assign cell_last   = cell_valid & ocol_last & orow_last;

	assign info_s0.valid  = cell_valid;
	assign info_s0.row    = cell_valid ? CW'(orow_q) : '0;
	assign info_s0.col    = cell_valid ? CW'(ocol_q) : '0;
	assign info_s0.top    = (orow_q == '0);
	assign info_s0.bottom = orow_last;
	assign info_s0.left   = (ocol_q == '0);
	assign info_s0.right  = ocol_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= glm3_pkg::clamp_dim(CFG_W'(glm3_pkg::RESET_DIM), MAX_ROWS);
			cols_q     <= glm3_pkg::clamp_dim(CFG_W'(glm3_pkg::RESET_DIM), MAX_COLS);
			in_col_q   <= '0;
			warm_cnt_q <= '0;
			orow_q     <= '0;
			ocol_q     <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				glm3_pkg::REG_GRID_ROWS:
					rows_q <= glm3_pkg::clamp_dim(pwdata[CFG_W-1:0], MAX_ROWS);
				glm3_pkg::REG_GRID_COLS:
					cols_q <= glm3_pkg::clamp_dim(pwdata[CFG_W-1:0], MAX_COLS);
				default: rows_q <= rows_q;
			endcase
			in_col_q   <= '0;
			warm_cnt_q <= '0;
			orow_q     <= '0;
			ocol_q     <= '0;
		end else if (in_accept) begin
			if (cell_last) begin
				// The last cell of the grid is decided; the next word opens a new grid.
				in_col_q   <= '0;
				warm_cnt_q <= '0;
				orow_q     <= '0;
				ocol_q     <= '0;
			end else begin
				in_col_q <= in_col_last ? '0 : in_col_q + COL_AW'(1);
				if (!cell_valid) begin
					warm_cnt_q <= warm_cnt_q + WARM_W'(1);
				end else begin
					ocol_q <= ocol_last ? '0 : ocol_q + COL_AW'(1);
					if (ocol_last) begin
						orow_q <= orow_q + ROW_W'(1);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- line memory
	assign h_in = (s_tuser[0] == glm3_pkg::REQ_DRAIN) ? '0 : s_tdata[HEIGHT_WIDTH-1:0];

	glm3_line_ram #(
		.DEPTH  (MAX_COLS),
		.DATA_W (ENTRY_W),
		.ADDR_W (COL_AW)
	) u_line_ram (
		.clk     (clk),
		.rd_en   (in_accept),
		.rd_addr (in_col_q),
		.rd_data (rd_data),
		.wr_en   (vld_s1),
		.wr_addr (idx_s1),
		.wr_data (wr_data)
	);

	// An entry being written while the same entry is read must come from the write.
	assign entry   = fwd_s1 ? fwd_data_s1 : rd_data;
	assign old_a   = entry[ENTRY_W-1:HEIGHT_WIDTH];
	assign old_b   = entry[HEIGHT_WIDTH-1:0];
	assign wr_data = {old_b, h_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_accept;
			fwd_s1 <= in_accept & vld_s1 & (idx_s1 == in_col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			idx_s1      <= in_col_q;
			h_s1        <= h_in;
			info_s1     <= info_s0;
			fwd_data_s1 <= wr_data;
		end
	end

	// ---------------------------------------------------------------- decision
	glm3_peak_eval #(
		.HEIGHT_WIDTH (HEIGHT_WIDTH)
	) u_peak_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift_en  (vld_s1),
		.col_top   (old_a),
		.col_mid   (old_b),
		.col_bot   (h_s1),
		.info_s1   (info_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	glm3_out_fifo #(
		.DEPTH (DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (out_accept),
		.out_valid (m_tvalid),
		.out_data  (out_res)
	);

	// Words accepted but not yet delivered; bounded by the buffer depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			unique case ({in_accept, out_accept})
				2'b10:   inflight_q <= inflight_q + FILL_W'(1);
				2'b01:   inflight_q <= inflight_q - FILL_W'(1);
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	assign s_tready = (inflight_q < FILL_W'(DEPTH));

	assign m_tdata = glm3_pkg::OUT_TDATA_W'({out_res.peak, out_res.col, out_res.row});
	assign m_tuser = glm3_pkg::OUT_TUSER_W'(out_res.valid);

endmodule

// ===== hw/rtl/glm3_checker.sv =====
// ----------------------------------------------------------------------------
// glm3_checker: port level checks for the local maximum detector
// Watches the register writes and the master stream and checks that the
// result words stay consistent with the configured grid.
// ----------------------------------------------------------------------------
module glm3_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             psel,
	input logic                             penable,
	input logic                             pwrite,
	input logic [glm3_pkg::APB_ADDR_W-1:0]  paddr,
	input logic [glm3_pkg::APB_DATA_W-1:0]  pwdata,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [glm3_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [glm3_pkg::OUT_TUSER_W-1:0] m_tuser
);

	localparam int CFG_W = glm3_pkg::CFG_W;
	localparam int CW    = glm3_pkg::COORD_W;

	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;
	logic [CW-1:0]    word_row;
	logic [CW-1:0]    word_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_W'(glm3_pkg::RESET_DIM);
			cols_q <= CFG_W'(glm3_pkg::RESET_DIM);
		end else if (psel && penable && pwrite) begin
			if (glm3_pkg::reg_idx_t'(paddr[2]) == glm3_pkg::REG_GRID_ROWS) begin
				rows_q <= pwdata[CFG_W-1:0];
			end else begin
				cols_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	assign word_row = m_tdata[CW-1:0];
	assign word_col = m_tdata[2*CW-1:CW];

	// A word that decides no cell carries no position and no peak flag.
	a_idle_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("result word without a cell carries nonzero fields");

	a_padding_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[glm3_pkg::OUT_TDATA_W-1:glm3_pkg::OUT_USED_W] == '0)
		else $error("padding bits of the result word are not zero");

	// Decided cells lie inside the programmed grid (a zero register means one).
	a_col_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(CFG_W'(word_col) < cols_q) || (cols_q == '0 && word_col == '0))
		else $error("decided column lies outside the grid");

	a_row_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(CFG_W'(word_row) < rows_q) || (rows_q == '0 && word_row == '0))
		else $error("decided row lies outside the grid");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

endmodule

bind grid_local_maximum_3x3_core glm3_checker u_glm3_checker (.*);
